// ===== sv/rv64_instruction_execute_assert.svh =====
// ----------------------------------------------------------------------------
// rv64_instruction_execute_assert.svh
// Assertion macros for the RV64 execute block. Clocked on aclk, idle in reset.
// ----------------------------------------------------------------------------
`ifndef RV64_INSTRUCTION_EXECUTE_ASSERT_SVH
`define RV64_INSTRUCTION_EXECUTE_ASSERT_SVH

// condition holds at every edge out of reset
`define RVX_CHECK(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RVX_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define RVX_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants of the RV64 execute block.
// ----------------------------------------------------------------------------
package rvx_pkg;

    // major opcodes
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMMW = 7'b0011011;
    localparam logic [6:0] OPC_OPW    = 7'b0111011;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;
    localparam logic [6:0] F7_ALT = 7'b0100000;
    // funct6 of immediate shifts
    localparam logic [5:0] F6_BASE = 6'b000000;
    localparam logic [5:0] F6_ALT = 6'b010000;

    // memory request codes
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    // trap codes
    localparam logic [1:0] TRAP_NONE    = 2'd0;
    localparam logic [1:0] TRAP_EBREAK  = 2'd1;
    localparam logic [1:0] TRAP_ILLEGAL = 2'd2;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_SLT, ALU_SLTU, ALU_XOR, ALU_OR, ALU_AND,
        ALU_SLL, ALU_SRL, ALU_SRA, ALU_MUL, ALU_DIV
    } alu_op_t;

    // classified instruction, front to back
    typedef struct packed {
        alu_op_t     op;
        logic        word;
        logic [63:0] a;
        logic [63:0] b;
        logic        val_en;
        logic        rd_write;
        logic [4:0]  rd_index;
        logic [63:0] next_pc;
        logic [1:0]  mem_op;
        logic [63:0] mem_address;
        logic [1:0]  mem_size_log2;
        logic        load_unsigned;
        logic [63:0] store_data;
        logic [1:0]  trap;
    } uop_t;

    // one result item
    typedef struct packed {
        logic [63:0] next_pc;
        logic        rd_write;
        logic [4:0]  rd_index;
        logic [63:0] rd_value;
        logic [1:0]  mem_op;
        logic [63:0] mem_address;
        logic [1:0]  mem_size_log2;
        logic        load_unsigned;
        logic [63:0] store_data;
        logic [1:0]  trap;
    } result_t;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

// ===== sv/rvx_decode.sv =====
// ----------------------------------------------------------------------------
// rvx_decode
// Front end: decodes the word, checks legality, resolves control flow and
// memory requests, and sets up the ALU operands.
// ----------------------------------------------------------------------------
module rvx_decode (
    input  logic [31:0]    instruction,
    input  logic [63:0]    pc,
    input  logic [63:0]    rs1_value,
    input  logic [63:0]    rs2_value,
    output rvx_pkg::uop_t  uop
);
    import rvx_pkg::*;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic [63:0] pc_plus4;

    assign opc = instruction[6:0];
    assign f3  = instruction[14:12];
    assign f7  = instruction[31:25];
    assign rd  = instruction[11:7];

    // immediates
    assign imm_i = {{52{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{52{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_b = {{51{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};
    assign imm_j = {{43{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};
    assign imm_u = {{32{instruction[31]}}, instruction[31:12], 12'b0};
    assign pc_plus4 = pc + 64'd4;

    always_comb begin
        logic legal;
        logic wr;
        logic take;
        logic is_load;
        uop = '0;
        uop.op = ALU_ADD;
        uop.next_pc = pc_plus4;
        uop.trap = TRAP_NONE;
        uop.mem_op = MEM_NONE;
        legal = 1'b1;
        wr = 1'b0;
        take = 1'b0;
        is_load = 1'b0;

        case (opc)
            OPC_LUI: begin
                wr = 1'b1;
                uop.b = imm_u;
            end
            OPC_AUIPC: begin
                wr = 1'b1;
                uop.a = pc;
                uop.b = imm_u;
            end
            OPC_JAL: begin
                wr = 1'b1;
                uop.a = pc;
                uop.b = 64'd4;
                uop.next_pc = pc + imm_j;
            end
            OPC_JALR: begin
                if (f3 != 3'd0) begin
                    legal = 1'b0;
                end else begin
                    wr = 1'b1;
                    uop.a = pc;
                    uop.b = 64'd4;
                    uop.next_pc = (rs1_value + imm_i) & ~64'd1;
                end
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0: take = (rs1_value == rs2_value);
                    3'd1: take = (rs1_value != rs2_value);
                    3'd4: take = ($signed(rs1_value) < $signed(rs2_value));
                    3'd5: take = ($signed(rs1_value) >= $signed(rs2_value));
                    3'd6: take = (rs1_value < rs2_value);
                    3'd7: take = (rs1_value >= rs2_value);
                    default: legal = 1'b0;
                endcase
                if (take) begin
                    uop.next_pc = pc + imm_b;
                end
            end
            OPC_LOAD: begin
                if (f3 == 3'd7) begin
                    legal = 1'b0;
                end else begin
                    wr = 1'b1;
                    is_load = 1'b1;
                    uop.mem_op = MEM_LOAD;
                    uop.mem_size_log2 = f3[1:0];
                    uop.load_unsigned = f3[2];
                    uop.mem_address = rs1_value + imm_i;
                end
            end
            OPC_STORE: begin
                if (f3[2]) begin
                    legal = 1'b0;
                end else begin
                    uop.mem_op = MEM_STORE;
                    uop.mem_size_log2 = f3[1:0];
                    uop.mem_address = rs1_value + imm_s;
                    case (f3[1:0])
                        2'd0: uop.store_data = {56'b0, rs2_value[7:0]};
                        2'd1: uop.store_data = {48'b0, rs2_value[15:0]};
                        2'd2: uop.store_data = {32'b0, rs2_value[31:0]};
                        default: uop.store_data = rs2_value;
                    endcase
                end
            end
            OPC_OPIMM: begin
                wr = 1'b1;
                uop.a = rs1_value;
                uop.b = imm_i;
                case (f3)
                    3'd0: uop.op = ALU_ADD;
                    3'd2: uop.op = ALU_SLT;
                    3'd3: uop.op = ALU_SLTU;
                    3'd4: uop.op = ALU_XOR;
                    3'd6: uop.op = ALU_OR;
                    3'd7: uop.op = ALU_AND;
                    3'd1: begin
                        uop.op = ALU_SLL;
                        legal = (f7[6:1] == F6_BASE);
                    end
                    default: begin
                        if (f7[6:1] == F6_BASE) begin
                            uop.op = ALU_SRL;
                        end else if (f7[6:1] == F6_ALT) begin
                            uop.op = ALU_SRA;
                        end else begin
                            legal = 1'b0;
                        end
                    end
                endcase
            end
            OPC_OP: begin
                wr = 1'b1;
                uop.a = rs1_value;
                uop.b = rs2_value;
                if (f7 == F7_MULDIV) begin
                    if (f3 == 3'd0) uop.op = ALU_MUL;
                    else if (f3 == 3'd4) uop.op = ALU_DIV;
                    else legal = 1'b0;
                end else if (f7 == F7_ALT) begin
                    if (f3 == 3'd0) uop.op = ALU_SUB;
                    else if (f3 == 3'd5) uop.op = ALU_SRA;
                    else legal = 1'b0;
                end else if (f7 != F7_BASE) begin
                    legal = 1'b0;
                end else begin
                    case (f3)
                        3'd0: uop.op = ALU_ADD;
                        3'd1: uop.op = ALU_SLL;
                        3'd2: uop.op = ALU_SLT;
                        3'd3: uop.op = ALU_SLTU;
                        3'd4: uop.op = ALU_XOR;
                        3'd5: uop.op = ALU_SRL;
                        3'd6: uop.op = ALU_OR;
                        default: uop.op = ALU_AND;
                    endcase
                end
            end
            OPC_OPIMMW: begin
                wr = 1'b1;
                uop.word = 1'b1;
                uop.a = rs1_value;
                uop.b = imm_i;
                if (f3 == 3'd0) begin
                    uop.op = ALU_ADD;
                end else if (f7 == F7_BASE && f3 == 3'd1) begin
                    uop.op = ALU_SLL;
                end else if (f7 == F7_BASE && f3 == 3'd5) begin
                    uop.op = ALU_SRL;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    uop.op = ALU_SRA;
                end else begin
                    legal = 1'b0;
                end
            end
            OPC_OPW: begin
                wr = 1'b1;
                uop.word = 1'b1;
                uop.a = rs1_value;
                uop.b = rs2_value;
                if (f7 == F7_MULDIV && f3 == 3'd0) begin
                    uop.op = ALU_MUL;
                end else if (f7 == F7_BASE && f3 == 3'd0) begin
                    uop.op = ALU_ADD;
                end else if (f7 == F7_BASE && f3 == 3'd1) begin
                    uop.op = ALU_SLL;
                end else if (f7 == F7_BASE && f3 == 3'd5) begin
                    uop.op = ALU_SRL;
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    uop.op = ALU_SUB;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    uop.op = ALU_SRA;
                end else begin
                    legal = 1'b0;
                end
            end
            OPC_SYSTEM: begin
                if (instruction == EBREAK_WORD) uop.trap = TRAP_EBREAK;
                else legal = 1'b0;
            end
            default: legal = 1'b0;
        endcase

        // illegal encodings drop every side effect
        if (!legal) begin
            uop = '0;
            uop.op = ALU_ADD;
            uop.next_pc = pc_plus4;
            uop.trap = TRAP_ILLEGAL;
            uop.mem_op = MEM_NONE;
            wr = 1'b0;
            is_load = 1'b0;
        end

        uop.rd_index = wr ? rd : 5'd0;
        uop.rd_write = wr && (rd != 5'd0);
        uop.val_en = wr && (rd != 5'd0) && !is_load;
    end

endmodule

// ===== sv/rvx_queue.sv =====
// ----------------------------------------------------------------------------
// rvx_queue
// Small FIFO of decoded instructions between front and back end.
// ----------------------------------------------------------------------------
module rvx_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rvx_pkg::uop_t  push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rvx_pkg::uop_t  head_item
);
    import rvx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uop_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== sv/rvx_execute.sv =====
// ----------------------------------------------------------------------------
// rvx_execute
// Back end: combinational ALU, sequenced 32x32 multiplier, radix-2 divider,
// and the registered result stage.
// ----------------------------------------------------------------------------
module rvx_execute (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  rvx_pkg::uop_t     q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output rvx_pkg::result_t  m_item
);
    import rvx_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_DONE} state_t;

    state_t      state_reg;
    logic        m_valid_reg;
    result_t     m_item_reg;
    uop_t        held_reg;
    logic [63:0] res_reg;
    logic [63:0] prod_reg, acc_reg;
    logic [1:0]  step_reg;
    logic [63:0] rem_reg, quo_reg, dvs_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;

    logic        out_free, is_long;
    logic [63:0] alu_r, shift_src;
    logic [5:0]  sh;
    logic [31:0] mul_x, mul_y;
    logic [64:0] trial;

    function automatic result_t to_result(input uop_t u, input logic [63:0] v);
        result_t r;
        r.next_pc       = u.next_pc;
        r.rd_write      = u.rd_write;
        r.rd_index      = u.rd_index;
        r.rd_value      = u.val_en ? v : 64'd0;
        r.mem_op        = u.mem_op;
        r.mem_address   = u.mem_address;
        r.mem_size_log2 = u.mem_size_log2;
        r.load_unsigned = u.load_unsigned;
        r.store_data    = u.store_data;
        r.trap          = u.trap;
        return r;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign is_long  = (q_item.op == ALU_MUL) || (q_item.op == ALU_DIV);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid && (is_long || out_free);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // combinational ALU on the queue head
    assign sh = q_item.word ? {1'b0, q_item.b[4:0]} : q_item.b[5:0];
    always_comb begin
        logic [63:0] r;
        if (q_item.word) begin
            shift_src = (q_item.op == ALU_SRA) ? sext32(q_item.a[31:0])
                                               : {32'b0, q_item.a[31:0]};
        end else begin
            shift_src = q_item.a;
        end
        case (q_item.op)
            ALU_ADD:  r = q_item.a + q_item.b;
            ALU_SUB:  r = q_item.a - q_item.b;
            ALU_SLT:  r = {63'b0, $signed(q_item.a) < $signed(q_item.b)};
            ALU_SLTU: r = {63'b0, q_item.a < q_item.b};
            ALU_XOR:  r = q_item.a ^ q_item.b;
            ALU_OR:   r = q_item.a | q_item.b;
            ALU_AND:  r = q_item.a & q_item.b;
            ALU_SLL:  r = shift_src << sh;
            ALU_SRL:  r = shift_src >> sh;
            ALU_SRA:  r = $unsigned($signed(shift_src) >>> sh);
            default:  r = 64'd0;
        endcase
        alu_r = q_item.word ? sext32(r[31:0]) : r;
    end

    // multiplier operand select: lo*lo, lo*hi, hi*lo
    assign mul_x = (step_reg == 2'd2) ? held_reg.a[63:32] : held_reg.a[31:0];
    assign mul_y = (step_reg == 2'd1) ? held_reg.b[63:32] : held_reg.b[31:0];

    // divider trial subtract
    assign trial = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};

    // sequencer, long ops and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && is_long) begin
                        held_reg <= q_item;
                        step_reg <= 2'd0;
                        cnt_reg  <= 6'd0;
                        rem_reg  <= 64'd0;
                        neg_reg  <= q_item.a[63] ^ q_item.b[63];
                        quo_reg  <= q_item.a[63] ? (64'd0 - q_item.a) : q_item.a;
                        dvs_reg  <= q_item.b[63] ? (64'd0 - q_item.b) : q_item.b;
                        if (q_item.op == ALU_MUL) begin
                            state_reg <= ST_MUL;
                        end else if (q_item.b == 64'd0) begin
                            res_reg   <= '1;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end else if (q_valid && out_free) begin
                        m_valid_reg <= 1'b1;
                        m_item_reg  <= to_result(q_item, alu_r);
                    end
                end
                ST_MUL: begin
                    prod_reg <= mul_x * mul_y;
                    step_reg <= step_reg + 2'd1;
                    case (step_reg)
                        2'd1: begin
                            acc_reg <= prod_reg;
                            if (held_reg.word) begin
                                res_reg   <= sext32(prod_reg[31:0]);
                                state_reg <= ST_DONE;
                            end
                        end
                        2'd2: acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                        2'd3: begin
                            res_reg   <= {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                            state_reg <= ST_DONE;
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (!trial[64]) begin
                        rem_reg <= trial[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[62:0], quo_reg[63]};
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    res_reg   <= neg_reg ? (64'd0 - quo_reg) : quo_reg;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_item_reg  <= to_result(held_reg, res_reg);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/rv64_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// rv64_instruction_execute
// RV64I execute unit with mul, div and mulw: decode front end, instruction
// queue, and execute back end with a registered result stage.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  s_        in   instruction, pc, rs1_value, rs2_value     s_tvalid/s_tready
//  m_        out  next_pc ... trap (one result per item)    m_tvalid/m_tready
//
//  ALU, branch, jump, load, store, trap: one item per cycle while m_tready
//  holds and no mul or div is busy; results pass the queue and the result
//  register. mul, mulw and div run on the shared 32x32 multiplier and the
//  one-bit-per-cycle divider; the queue keeps the front accepting while the
//  back end works. Reset clears the queue and sequencer; no clearing pass.
// ----------------------------------------------------------------------------
module rv64_instruction_execute #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // instruction[31:0], pc[95:32], rs1_value[159:96], rs2_value[223:160]
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[63:0], rd_write[64], rd_index[69:65], rd_value[133:70],
    // mem_op[135:134], mem_address[199:136], mem_size_log2[201:200],
    // load_unsigned[202], store_data[266:203], trap[268:267], zero pad
    output logic [271:0] m_tdata
);
    import rvx_pkg::*;

    uop_t    dec_uop, head_uop;
    logic    q_full, q_valid, q_pop, push;
    result_t res;
    logic    is_long_head;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    // front end
    rvx_decode u_decode (
        .instruction (s_tdata[31:0]),
        .pc          (s_tdata[95:32]),
        .rs1_value   (s_tdata[159:96]),
        .rs2_value   (s_tdata[223:160]),
        .uop         (dec_uop)
    );

    // decoupling queue
    rvx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (dec_uop),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_uop)
    );

    // back end
    rvx_execute u_execute (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (head_uop),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (res)
    );

    assign m_tdata = {3'b000, res.trap, res.store_data, res.load_unsigned, res.mem_size_log2,
                      res.mem_address, res.mem_op, res.rd_value, res.rd_index,
                      res.rd_write, res.next_pc};

    assign is_long_head = (head_uop.op == ALU_MUL) || (head_uop.op == ALU_DIV);

    `include "rv64_instruction_execute_assert.svh"

    `RVX_IMPLY(a_wr_no_x0, m_tvalid && res.rd_write, res.rd_index != 5'd0 && res.trap == TRAP_NONE, "register write to x0 or with trap")
    `RVX_IMPLY(a_trap_quiet, m_tvalid && res.trap != TRAP_NONE, res.mem_op == MEM_NONE && !res.rd_write, "trap with side effect")
    `RVX_IMPLY(a_load_value, m_tvalid && res.mem_op == MEM_LOAD, res.rd_value == 64'd0, "load carries a value")
    `RVX_NEXT(a_pop_feeds, q_pop && !is_long_head, m_tvalid, "simple item left no result")

endmodule

// ===== test/rv64_instruction_execute_test.sv =====
// ----------------------------------------------------------------------------
// rv64_instruction_execute_test
// Self-checking bench for the RV64 execute unit. Directed instructions cover
// a selection of operations and the edge cases (x0 loads, traps, divide
// corner cases, a bad shift encoding); random instructions follow, mostly
// well-formed with random operands, plus raw noise words. A scoreboard
// predicts each result and compares it field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rv64_instruction_execute_test;
    import rvx_pkg::*;

    // execute result prediction and in-order checking
    class exec_scoreboard;
        result_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function automatic logic [63:0] sra(input logic [63:0] a, input int sh);
            return $signed(a) >>> sh;
        endfunction

        function automatic logic [63:0] quotient(input logic [63:0] a, input logic [63:0] b);
            if (b == 0) return '1;
            if (a == 64'h8000_0000_0000_0000 && b == '1) return a;
            return $signed(a) / $signed(b);
        endfunction

        function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
            return $signed(a) < $signed(b);
        endfunction

        // noted on each accepted input item
        function void note_instruction(input logic [31:0] ins, input logic [63:0] pc,
                                       input logic [63:0] a, input logic [63:0] b);
            result_t r;
            logic [6:0] opc, f7;
            logic [2:0] f3;
            logic [4:0] rd;
            logic [63:0] ii, is, ib, ij, iu, val, op2;
            logic ok, wr, take;
            int sh;
            opc = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25]; rd = ins[11:7];
            ii = {{52{ins[31]}}, ins[31:20]};
            is = {{52{ins[31]}}, ins[31:25], ins[11:7]};
            ib = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            ij = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            iu = {{32{ins[31]}}, ins[31:12], 12'b0};
            r = '0; r.next_pc = pc + 4; ok = 1; wr = 0; val = 0; take = 0;
            case (opc)
                OPC_LUI: begin wr = 1; val = iu; end
                OPC_AUIPC: begin wr = 1; val = pc + iu; end
                OPC_JAL: begin wr = 1; val = pc + 4; r.next_pc = pc + ij; end
                OPC_JALR: begin
                    if (f3 != 0) ok = 0;
                    else begin
                        wr = 1; val = pc + 4; r.next_pc = (a + ii) & ~64'd1;
                    end
                end
                OPC_BRANCH: begin
                    case (f3)
                        3'd0: take = a == b;
                        3'd1: take = a != b;
                        3'd4: take = slt(a, b);
                        3'd5: take = !slt(a, b);
                        3'd6: take = a < b;
                        3'd7: take = a >= b;
                        default: ok = 0;
                    endcase
                    if (take) r.next_pc = pc + ib;
                end
                OPC_LOAD: begin
                    if (f3 == 3'd7) ok = 0;
                    else begin
                        r.mem_op = MEM_LOAD; wr = 1; r.mem_size_log2 = f3[1:0];
                        r.load_unsigned = f3[2]; r.mem_address = a + ii;
                    end
                end
                OPC_STORE: begin
                    if (f3 > 3) ok = 0;
                    else begin
                        r.mem_op = MEM_STORE; r.mem_size_log2 = f3[1:0];
                        r.mem_address = a + is;
                        case (f3[1:0])
                            2'd0: r.store_data = {56'b0, b[7:0]};
                            2'd1: r.store_data = {48'b0, b[15:0]};
                            2'd2: r.store_data = {32'b0, b[31:0]};
                            default: r.store_data = b;
                        endcase
                    end
                end
                OPC_OPIMM, OPC_OP: begin
                    op2 = (opc == OPC_OP) ? b : ii;
                    sh = int'(op2[5:0]);
                    if (opc == OPC_OP && f7 == F7_MULDIV) begin
                        if (f3 == 0) val = a * b;
                        else if (f3 == 4) val = quotient(a, b);
                        else ok = 0;
                    end else if (opc == OPC_OP && f7 == F7_ALT) begin
                        if (f3 == 0) val = a - b;
                        else if (f3 == 5) val = sra(a, sh);
                        else ok = 0;
                    end else if (opc == OPC_OP && f7 != F7_BASE) begin
                        ok = 0;
                    end else begin
                        case (f3)
                            3'd0: val = a + op2;
                            3'd2: val = {63'b0, slt(a, op2)};
                            3'd3: val = {63'b0, a < op2};
                            3'd4: val = a ^ op2;
                            3'd6: val = a | op2;
                            3'd7: val = a & op2;
                            3'd1: begin
                                if (opc == OPC_OPIMM ? f7[6:1] != F6_BASE : 0) ok = 0;
                                else val = a << sh;
                            end
                            default: begin
                                if (opc == OPC_OPIMM ? f7[6:1] == F6_BASE : 1)
                                    val = a >> sh;
                                else if (f7[6:1] == F6_ALT) val = sra(a, sh);
                                else ok = 0;
                            end
                        endcase
                    end
                    wr = ok;
                end
                OPC_OPIMMW, OPC_OPW: begin
                    op2 = (opc == OPC_OPW) ? b : ii;
                    sh = int'(op2[4:0]);
                    if (opc == OPC_OPIMMW && f3 == 0) val = sext32(a[31:0] + op2[31:0]);
                    else if (opc == OPC_OPW && f7 == F7_MULDIV) begin
                        if (f3 == 0) val = sext32(a[31:0] * b[31:0]);
                        else ok = 0;
                    end else if (f7 == F7_BASE) begin
                        if (f3 == 0 && opc == OPC_OPW) val = sext32(a[31:0] + b[31:0]);
                        else if (f3 == 1) val = sext32(a[31:0] << sh);
                        else if (f3 == 5) val = sext32(a[31:0] >> sh);
                        else ok = 0;
                    end else if (f7 == F7_ALT) begin
                        if (f3 == 0 && opc == OPC_OPW) val = sext32(a[31:0] - b[31:0]);
                        else if (f3 == 5) val = sext32($signed(a[31:0]) >>> sh);
                        else ok = 0;
                    end else ok = 0;
                    wr = ok;
                end
                OPC_SYSTEM: begin
                    if (ins == EBREAK_WORD) r.trap = TRAP_EBREAK;
                    else ok = 0;
                end
                default: ok = 0;
            endcase
            if (!ok) begin
                r = '0; r.next_pc = pc + 4; r.trap = TRAP_ILLEGAL; wr = 0;
            end
            if (r.mem_op == MEM_LOAD) val = 0;
            r.rd_write = wr && rd != 0;
            r.rd_index = (wr || r.mem_op == MEM_LOAD) ? rd : 5'd0;
            r.rd_value = r.rd_write ? val : 64'd0;
            pending.push_back(r);
        endfunction

        // compares one accepted result with the oldest prediction
        function void check_result(input result_t got);
            result_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.next_pc !== exp.next_pc) report("next_pc", exp.next_pc, got.next_pc);
            if (got.rd_write !== exp.rd_write) report("rd_write", exp.rd_write, got.rd_write);
            if (got.rd_index !== exp.rd_index) report("rd_index", exp.rd_index, got.rd_index);
            if (got.rd_value !== exp.rd_value) report("rd_value", exp.rd_value, got.rd_value);
            if (got.mem_op !== exp.mem_op) report("mem_op", exp.mem_op, got.mem_op);
            if (got.mem_address !== exp.mem_address)
                report("mem_address", exp.mem_address, got.mem_address);
            if (got.mem_size_log2 !== exp.mem_size_log2)
                report("mem_size_log2", exp.mem_size_log2, got.mem_size_log2);
            if (got.load_unsigned !== exp.load_unsigned)
                report("load_unsigned", exp.load_unsigned, got.load_unsigned);
            if (got.store_data !== exp.store_data)
                report("store_data", exp.store_data, got.store_data);
            if (got.trap !== exp.trap) report("trap", exp.trap, got.trap);
        endfunction

        function void report(input string name, input logic [63:0] exp, input logic [63:0] act);
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp, act);
            errors++;
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [223:0] s_tdata;
    logic [271:0] m_tdata;
    int send_idle_pct, recv_idle_pct;
    bit stim_done;
    exec_scoreboard sb;

    rv64_instruction_execute dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("rv64_instruction_execute_test failed");
        $finish;
    end

    // result item fields, lowest bits first
    function automatic result_t unpack_result(input logic [271:0] d);
        result_t r;
        r.next_pc       = d[63:0];
        r.rd_write      = d[64];
        r.rd_index      = d[69:65];
        r.rd_value      = d[133:70];
        r.mem_op        = d[135:134];
        r.mem_address   = d[199:136];
        r.mem_size_log2 = d[201:200];
        r.load_unsigned = d[202];
        r.store_data    = d[266:203];
        r.trap          = d[268:267];
        return r;
    endfunction

    // result side: random stalls, check at rising edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(unpack_result(m_tdata));
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return {1'($urandom_range(1)), 63'd0} | 64'($urandom_range(7));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one item on the input side, optional idle gap first
    task automatic send_item(input logic [31:0] ins, input logic [63:0] pc,
                             input logic [63:0] a, input logic [63:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {b, a, pc, ins};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_instruction(ins, pc, a, b);
        @(negedge aclk);
    endtask

    // instruction of a random kind with random fields, mostly well-formed
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        logic [2:0] f3;
        w = $urandom;
        f3 = w[14:12];
        case ($urandom_range(13))
            0: w[6:0] = OPC_LUI;
            1: w[6:0] = OPC_AUIPC;
            2: w[6:0] = OPC_JAL;
            3: begin w[6:0] = OPC_JALR; w[14:12] = 3'd0; end
            4: begin
                w[6:0] = OPC_BRANCH;
                if (f3 == 2 || f3 == 3) w[14:12] = f3 + 3'd4;
            end
            5: begin w[6:0] = OPC_LOAD; if (f3 == 7) w[14:12] = 3'd6; end
            6: begin w[6:0] = OPC_STORE; w[14] = 0; end
            7: begin
                w[6:0] = OPC_OPIMM;
                if (f3 == 1 || f3 == 5)
                    w[31:26] = (f3 == 5 && w[31]) ? F6_ALT : F6_BASE;
            end
            8, 9: begin
                w[6:0] = OPC_OP;
                case ($urandom_range(3))
                    0: w[31:25] = F7_MULDIV;
                    1: w[31:25] = F7_ALT;
                    default: w[31:25] = F7_BASE;
                endcase
                if (w[31:25] == F7_MULDIV) w[14:12] = w[12] ? 3'd4 : 3'd0;
                if (w[31:25] == F7_ALT) w[14:12] = w[12] ? 3'd5 : 3'd0;
            end
            10: begin
                w[6:0] = OPC_OPIMMW;
                if (f3 != 0) begin
                    w[14:12] = w[13] ? 3'd5 : 3'd1;
                    w[31:25] = (w[14] && w[31]) ? F7_ALT : F7_BASE;
                end
            end
            11: begin
                w[6:0] = OPC_OPW;
                w[31:25] = w[31] ? F7_ALT : (w[30] ? F7_MULDIV : F7_BASE);
                w[14:12] = w[12] ? 3'd5 : 3'd0;
                if (w[31:25] == F7_BASE && w[13]) w[14:12] = 3'd1;
                if (w[31:25] == F7_MULDIV) w[14:12] = 3'd0;
            end
            12: w = EBREAK_WORD;
            default: ;  // raw noise
        endcase
        return w;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_item(random_instruction(), rand64(), rand64(), rand64());
    endtask

    initial begin
        logic [63:0] mn;
        sb = new();
        mn = 64'h8000_0000_0000_0000;
        aresetn = 0; s_tvalid = 0; s_tdata = '0; m_tready = 0;
        send_idle_pct = 38; recv_idle_pct = 62;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: operations, extremes and corner cases
        send_item(32'hFFFF_F0B7, '1, 0, 0);            // lui, top pc
        send_item(32'h8000_0097, 64'h1000, 0, 0);      // auipc negative
        send_item(32'h8000_00EF, 64'h8000, 0, 0);      // jal backward
        send_item(32'hFFF0_8067, 0, '1, 0);            // jalr to x0, bit0 cleared
        send_item(32'h0020_C463, 0, mn, 1);            // blt taken
        send_item(32'h0020_F463, 0, mn, 1);            // bgeu taken
        send_item(32'h0020_2463, 0, 0, 0);             // branch funct3 2 invalid
        send_item(32'h0000_3003, 0, '1, 0);            // ld into x0
        send_item(32'hFFF0_6283, 0, 0, 0);             // lwu
        send_item(32'h0000_7283, 0, 0, 0);             // load funct3 7 invalid
        send_item(32'hFE20_0FA3, 0, 64'h10, '1);       // sb
        send_item(32'h0020_3023, 0, 0, '1);            // sd
        send_item(32'h0020_4023, 0, 0, '1);            // store funct3 4 invalid
        send_item(32'h0220_C2B3, 0, 5, 0);             // div by zero
        send_item(32'h0220_C2B3, 0, mn, '1);           // div overflow
        send_item(32'h0220_C2B3, 0, -64'sd7, 2);       // div truncation
        send_item(32'h0220_82B3, 0, '1, '1);           // mul
        send_item(32'h0220_82BB, 0, 64'hFFFF, 64'h10001); // mulw
        send_item(32'h43F0_D293, 0, mn, 0);            // srai 63
        send_item(32'h4010_D293, 0, mn, 0);            // srai 1
        send_item(32'h0200_9293, 0, 1, 0);             // slli 32
        send_item(32'h41F0_D29B, 0, 64'h8000_0000, 0); // sraiw 31
        send_item(32'h0210_929B, 0, 1, 0);             // slliw bit25: invalid
        send_item(EBREAK_WORD, '1, 0, 0);              // ebreak
        send_item(32'h0000_0073, 0, 0, 0);             // ecall: invalid

        run_random(600);
        send_idle_pct = 62; recv_idle_pct = 38;
        run_random(550);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(550);

        s_tvalid <= 0;
        stim_done = 1;
    end

    // end of run: drain, settle, report
    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("rv64_instruction_execute_test passed");
        else
            $display("rv64_instruction_execute_test failed");
        $finish;
    end
endmodule
